// ===== sv/frequency_ordered_list_locate_macros.svh =====
// ----------------------------------------------------------------------------
// Frequency ordered list: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_ORDERED_LIST_LOCATE_MACROS_SVH
`define FREQUENCY_ORDERED_LIST_LOCATE_MACROS_SVH

// Same-cycle implication.
`define FOL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FOL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fol_pkg.sv =====
// ----------------------------------------------------------------------------
// Frequency ordered list: package
// Request and status codes, cell command type.
// ----------------------------------------------------------------------------
package fol_pkg;

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_LOCATE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    // broadcast to every cell
    typedef struct packed {
        logic find;   // latch frontmost match
        logic move;   // apply locate reorder
    } fol_cmd_t;

endpackage

// ===== sv/fol_req_if.sv =====
// ----------------------------------------------------------------------------
// Frequency ordered list: request channel
// valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface fol_req_if;

    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] symbol;
    logic [3:0] index;

    modport source (output valid, output req_type, output symbol, output index,
                    input ready);
    modport sink   (input valid, input req_type, input symbol, input index,
                    output ready);

endinterface

// ===== sv/fol_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Frequency ordered list: response channel
// valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface fol_rsp_if;

    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  symbol_out;
    logic [15:0] count_out;
    logic [3:0]  position;

    modport source (output valid, output status, output symbol_out,
                    output count_out, output position, input ready);
    modport sink   (input valid, input status, input symbol_out,
                    input count_out, input position, output ready);

endinterface

// ===== sv/fol_cell.sv =====
// ----------------------------------------------------------------------------
// Frequency ordered list: list cell
// One list position: symbol and count, match and reorder decisions.
// ----------------------------------------------------------------------------
module fol_cell
    import fol_pkg::*;
#(
    parameter int SYMBOL_BITS = 8,
    parameter int COUNT_BITS  = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  fol_cmd_t               cmd,
    input  logic                   entry_valid,
    input  logic                   append_here,
    input  logic [SYMBOL_BITS-1:0] key,
    input  logic [COUNT_BITS-1:0]  new_count,
    input  logic [SYMBOL_BITS-1:0] left_symbol,
    input  logic [COUNT_BITS-1:0]  left_count,
    input  logic                   found_in,
    output logic                   found_out,
    input  logic                   after_in,
    output logic                   after_out,
    input  logic                   lt_in,
    output logic                   lt_out,
    output logic                   hit,
    output logic                   target,
    output logic [SYMBOL_BITS-1:0] symbol,
    output logic [COUNT_BITS-1:0]  count
);

    logic [SYMBOL_BITS-1:0] sym_reg;
    logic [COUNT_BITS-1:0]  cnt_reg;
    logic                   hit_reg;
    logic                   match;
    logic                   span;
    logic                   shift;

    assign match     = entry_valid && (sym_reg == key);
    assign found_out = found_in | match;

    // after_in: the hit lies further toward the tail
    assign after_out = hit_reg | after_in;
    assign lt_out    = after_in && (cnt_reg < new_count);
    assign span      = after_in | hit_reg;
    assign shift     = cmd.move && lt_in && span;
    assign target    = span && !lt_in && (lt_out || hit_reg);

    assign hit    = hit_reg;
    assign symbol = sym_reg;
    assign count  = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.find)
        begin
            hit_reg <= match && !found_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (append_here)
        begin
            sym_reg <= key;
            cnt_reg <= '0;
        end
        else if (shift)
        begin
            sym_reg <= left_symbol;
            cnt_reg <= left_count;
        end
        else if (cmd.move && target)
        begin
            sym_reg <= key;
            cnt_reg <= new_count;
        end
    end

endmodule

// ===== sv/frequency_ordered_list_locate.sv =====
// ----------------------------------------------------------------------------
// Frequency ordered list locate: top level
// Self-organizing list kept in a row of cells, ordered by access count.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   handshake
//  req      in   req_type, symbol, index                   valid/ready
//  rsp      out  status, symbol_out, count_out, position   valid/ready
//
//  Every item passes the accept edge, where all cells compare the symbol in
//  parallel, and then the execute edge, where the cells shift/load.
//  A new item is not accepted until the last one has finished its
//  compare-then-reorder pass through the cell row.
//  A stalled rsp holds the execute step until the output register frees.
//  Reset empties the list; no clearing pass, cells beyond the fill count
//  are never read.
// ----------------------------------------------------------------------------
`include "frequency_ordered_list_locate_macros.svh"

module frequency_ordered_list_locate
    import fol_pkg::*;
#(
    parameter int LIST_DEPTH  = 16,
    parameter int COUNT_BITS  = 16,
    parameter int SYMBOL_BITS = 8
)
(
    input  logic     clk,
    input  logic     rst_n,
    fol_req_if.sink  req,
    fol_rsp_if.source rsp
);

    localparam int IW = $clog2(LIST_DEPTH);
    localparam int TW = $clog2(LIST_DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    // control
    logic                   state_reg, state_next;
    logic [TW-1:0]          total_reg, total_next;
    logic                   found_any_reg;

    // captured request
    logic [1:0]             type_reg;
    logic [SYMBOL_BITS-1:0] key_reg;
    logic [3:0]             idx_reg;

    // output register
    logic                   out_valid_reg;
    logic [1:0]             status_reg;
    logic [7:0]             sym_out_reg;
    logic [15:0]            cnt_out_reg;
    logic [3:0]             pos_out_reg;

    logic                   accept;
    logic                   go;
    logic                   full;
    logic                   read_ok;
    logic                   do_append;
    logic                   do_move;
    fol_cmd_t               cmd;
    logic [SYMBOL_BITS-1:0] key;

    // cell row wiring
    logic [SYMBOL_BITS-1:0] sym_arr  [LIST_DEPTH];
    logic [COUNT_BITS-1:0]  cnt_arr  [LIST_DEPTH];
    logic [SYMBOL_BITS-1:0] left_sym [LIST_DEPTH];
    logic [COUNT_BITS-1:0]  left_cnt [LIST_DEPTH];
    logic [LIST_DEPTH:0]    found_ch;
    logic [LIST_DEPTH:0]    after_ch;
    logic [LIST_DEPTH:0]    lt_ch;
    logic [LIST_DEPTH-1:0]  hit_vec;
    logic [LIST_DEPTH-1:0]  target_vec;
    logic [LIST_DEPTH-1:0]  valid_vec;
    logic [LIST_DEPTH-1:0]  append_vec;
    logic [LIST_DEPTH-1:0]  sel_vec;

    // reductions over the row
    logic [COUNT_BITS-1:0]  hit_cnt;
    logic [COUNT_BITS-1:0]  new_cnt;
    logic [SYMBOL_BITS-1:0] rd_sym;
    logic [COUNT_BITS-1:0]  rd_cnt;
    logic [IW-1:0]          tgt_pos;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign go        = (state_reg == S_RUN) && (!out_valid_reg || rsp.ready);

    assign full      = (total_reg >= TW'(LIST_DEPTH));
    assign read_ok   = (32'(idx_reg) < 32'(total_reg));
    assign do_append = go && (type_reg == REQ_APPEND) && !full;
    assign do_move   = go && (type_reg == REQ_LOCATE) && found_any_reg;

    assign cmd.find  = accept && (req.req_type == REQ_LOCATE);
    assign cmd.move  = do_move;

    // compare against live input on the accept edge, captured key later
    assign key = (state_reg == S_IDLE) ? SYMBOL_BITS'(req.symbol) : key_reg;

    assign found_ch[0]          = 1'b0;
    assign lt_ch[0]             = 1'b0;
    assign after_ch[LIST_DEPTH] = 1'b0;

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        assign valid_vec[i]  = (total_reg > TW'(i));
        assign append_vec[i] = do_append && (total_reg == TW'(i));
        assign sel_vec[i]    = (32'(idx_reg) == 32'(i));

        if (i == 0)
        begin : g_front
            assign left_sym[i] = sym_arr[i];
            assign left_cnt[i] = cnt_arr[i];
        end
        else
        begin : g_rest
            assign left_sym[i] = sym_arr[i-1];
            assign left_cnt[i] = cnt_arr[i-1];
        end

        fol_cell #(
            .SYMBOL_BITS (SYMBOL_BITS),
            .COUNT_BITS  (COUNT_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .entry_valid (valid_vec[i]),
            .append_here (append_vec[i]),
            .key         (key),
            .new_count   (new_cnt),
            .left_symbol (left_sym[i]),
            .left_count  (left_cnt[i]),
            .found_in    (found_ch[i]),
            .found_out   (found_ch[i+1]),
            .after_in    (after_ch[i+1]),
            .after_out   (after_ch[i]),
            .lt_in       (lt_ch[i]),
            .lt_out      (lt_ch[i+1]),
            .hit         (hit_vec[i]),
            .target      (target_vec[i]),
            .symbol      (sym_arr[i]),
            .count       (cnt_arr[i])
        );
    end

    // one-hot selects: OR of gated values
    always_comb
    begin
        hit_cnt = '0;
        rd_sym  = '0;
        rd_cnt  = '0;
        tgt_pos = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (hit_vec[i])
            begin
                hit_cnt = hit_cnt | cnt_arr[i];
            end
            if (sel_vec[i])
            begin
                rd_sym = rd_sym | sym_arr[i];
                rd_cnt = rd_cnt | cnt_arr[i];
            end
            if (target_vec[i])
            begin
                tgt_pos = tgt_pos | IW'(i);
            end
        end
    end

    // saturating increment
    assign new_cnt = (hit_cnt == '1) ? hit_cnt : hit_cnt + COUNT_BITS'(1);

    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (go)
                begin
                    state_next = S_IDLE;
                end
                if (do_append)
                begin
                    total_next = total_reg + TW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            found_any_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            if (accept)
            begin
                found_any_reg <= found_ch[LIST_DEPTH];
            end
            if (go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg <= req.req_type;
            key_reg  <= SYMBOL_BITS'(req.symbol);
            idx_reg  <= req.index;
        end
        if (go)
        begin
            case (type_reg)
                REQ_APPEND:
                begin
                    status_reg  <= full ? ST_FULL : ST_OK;
                    sym_out_reg <= 8'(key_reg);
                    cnt_out_reg <= '0;
                    pos_out_reg <= full ? 4'd0 : 4'(total_reg);
                end
                REQ_LOCATE:
                begin
                    status_reg  <= found_any_reg ? ST_OK : ST_NOT_FOUND;
                    sym_out_reg <= 8'(key_reg);
                    cnt_out_reg <= found_any_reg ? 16'(new_cnt) : 16'd0;
                    pos_out_reg <= found_any_reg ? 4'(tgt_pos) : 4'd0;
                end
                REQ_READ:
                begin
                    status_reg  <= read_ok ? ST_OK : ST_BAD_INDEX;
                    sym_out_reg <= read_ok ? 8'(rd_sym) : 8'd0;
                    cnt_out_reg <= read_ok ? 16'(rd_cnt) : 16'd0;
                    pos_out_reg <= read_ok ? idx_reg : 4'd0;
                end
                default:
                begin
                    status_reg  <= ST_BAD_INDEX;
                    sym_out_reg <= '0;
                    cnt_out_reg <= '0;
                    pos_out_reg <= '0;
                end
            endcase
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.symbol_out = sym_out_reg;
    assign rsp.count_out  = cnt_out_reg;
    assign rsp.position   = pos_out_reg;

    `FOL_ASSERT_IMP(a_total_bound, 1'b1, total_reg <= TW'(LIST_DEPTH), "fill count above depth")
    `FOL_ASSERT_IMP(a_hit_single, state_reg == S_RUN, $onehot0(hit_vec), "more than one hit cell")
    `FOL_ASSERT_IMP(a_move_target, do_move, $onehot(target_vec) && $onehot(hit_vec), "reorder without single target")
    `FOL_ASSERT_NXT(a_append_grow, do_append, total_reg == $past(total_reg) + TW'(1), "append lost")

endmodule

// ===== sim/frequency_ordered_list_locate_test.sv =====
// ----------------------------------------------------------------------------
// Frequency ordered list locate: testbench
// A directed table is applied first. Its rows cover the empty list, misses,
// the unused request code, duplicate symbols, count ties and the full list.
// Random requests follow, with random idle gaps on both channels and one
// long response stall. Every result is checked field by field against the
// table's expected values or an in-bench model of the list.
// ----------------------------------------------------------------------------
module frequency_ordered_list_locate_test;

    import fol_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          LIST_DEPTH   = 16;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
    localparam logic [1:0]  REQ_RESERVED = 2'd3;    // unused request code

    localparam int RANDOM_ITEMS = 2000;
    localparam int MAX_WAIT     = 18;      // longest per-item idle, either side
    localparam int HOLD_AT      = 300;     // result count at the long stall
    localparam int HOLD_CYCLES  = 400;     // length of the long stall
    localparam int DRAIN_CYCLES = 20;      // quiet time at the end

    // Slowest correct run: about 2030 items, each with the longest idle on
    // both sides, plus one long stall. That is about 0.8 ms. The limit is
    // several times that.
    localparam realtime RUN_LIMIT = 5ms;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] symbol;
        logic [3:0] index;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  symbol_out;
        logic [15:0] count_out;
        logic [3:0]  position;
    } result_t;

    // One directed row. Where 'typed' is set, 'want' is the expected result.
    // Otherwise the list model supplies it.
    typedef struct packed {
        request_t req;
        logic     typed;
        result_t  want;
    } directed_row_t;

    localparam result_t BY_MODEL = '0;

    localparam int DIRECTED_ROWS = 26;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // empty list: bad read, miss, unused code
        '{'{REQ_READ,     8'h00, 4'd0},  1'b1, '{ST_BAD_INDEX, 8'h00, 16'd0, 4'd0}},
        '{'{REQ_LOCATE,   8'h5A, 4'd9},  1'b1, '{ST_NOT_FOUND, 8'h5A, 16'd0, 4'd0}},
        '{'{REQ_RESERVED, 8'hFF, 4'd15}, 1'b1, '{ST_BAD_INDEX, 8'h00, 16'd0, 4'd0}},
        // first entries, symbol extremes
        '{'{REQ_APPEND,   8'h00, 4'd15}, 1'b1, '{ST_OK,        8'h00, 16'd0, 4'd0}},
        '{'{REQ_APPEND,   8'hFF, 4'd0},  1'b1, '{ST_OK,        8'hFF, 16'd0, 4'd1}},
        '{'{REQ_READ,     8'h00, 4'd15}, 1'b1, '{ST_BAD_INDEX, 8'h00, 16'd0, 4'd0}},
        '{'{REQ_READ,     8'h00, 4'd1},  1'b1, '{ST_OK,        8'hFF, 16'd0, 4'd1}},
        // FF overtakes 00, then 00 ties at one and must not pass
        '{'{REQ_LOCATE,   8'hFF, 4'd0},  1'b0, BY_MODEL},
        '{'{REQ_LOCATE,   8'h00, 4'd0},  1'b0, BY_MODEL},
        // duplicate symbol: locate must only touch the frontmost copy
        '{'{REQ_APPEND,   8'h00, 4'd0},  1'b1, '{ST_OK,        8'h00, 16'd0, 4'd2}},
        '{'{REQ_LOCATE,   8'h00, 4'd0},  1'b0, BY_MODEL},
        // fill up, walking a one through the symbol, then other patterns
        '{'{REQ_APPEND,   8'h01, 4'd0},  1'b0, BY_MODEL},
        '{'{REQ_APPEND,   8'h02, 4'd0},  1'b0, BY_MODEL},
        '{'{REQ_APPEND,   8'h04, 4'd0},  1'b0, BY_MODEL},
        '{'{REQ_APPEND,   8'h08, 4'd0},  1'b0, BY_MODEL},
        '{'{REQ_APPEND,   8'h10, 4'd0},  1'b0, BY_MODEL},
        '{'{REQ_APPEND,   8'h20, 4'd0},  1'b0, BY_MODEL},
        '{'{REQ_APPEND,   8'h40, 4'd0},  1'b0, BY_MODEL},
        '{'{REQ_APPEND,   8'h80, 4'd0},  1'b0, BY_MODEL},
        '{'{REQ_APPEND,   8'h55, 4'd0},  1'b0, BY_MODEL},
        '{'{REQ_APPEND,   8'hAA, 4'd0},  1'b0, BY_MODEL},
        '{'{REQ_APPEND,   8'hFE, 4'd0},  1'b0, BY_MODEL},
        '{'{REQ_APPEND,   8'h7F, 4'd0},  1'b0, BY_MODEL},
        '{'{REQ_APPEND,   8'h33, 4'd0},  1'b0, BY_MODEL},
        // full list: the append is refused and the tail is readable
        '{'{REQ_APPEND,   8'hC3, 4'd0},  1'b1, '{ST_FULL,      8'hC3, 16'd0, 4'd0}},
        '{'{REQ_READ,     8'h00, 4'd15}, 1'b0, BY_MODEL}
    };

    logic clk;
    logic rst_n;

    fol_req_if req_ch ();
    fol_rsp_if rsp_ch ();

    frequency_ordered_list_locate i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Model of the list: symbols and counts, front first.
    logic [7:0]  list_symbol [LIST_DEPTH];
    logic [15:0] list_count  [LIST_DEPTH];
    int          list_fill;

    result_t expected_q [$];   // results still owed by the block
    int      error_count;
    int      results_taken;
    bit      no_idle;          // both sides run without gaps while set

    always
    begin
        #5 clk = ~clk;
    end

    // Apply one accepted request to the list model and return its result.
    function automatic result_t apply_request(input request_t r);
        result_t     res;
        int          hit;
        int          slot;
        logic [15:0] bumped;

        res = '{ST_BAD_INDEX, 8'h00, 16'd0, 4'd0};
        case (r.kind)
            REQ_APPEND:
            begin
                if (list_fill >= LIST_DEPTH)
                begin
                    res = '{ST_FULL, r.symbol, 16'd0, 4'd0};
                end
                else
                begin
                    list_symbol[list_fill] = r.symbol;
                    list_count[list_fill]  = 16'd0;
                    res = '{ST_OK, r.symbol, 16'd0, 4'(list_fill)};
                    list_fill++;
                end
            end
            REQ_LOCATE:
            begin
                hit = -1;
                for (int k = list_fill - 1; k >= 0; k--)
                begin
                    if (list_symbol[k] == r.symbol)
                    begin
                        hit = k;    // last one seen is the frontmost
                    end
                end
                if (hit < 0)
                begin
                    res = '{ST_NOT_FOUND, r.symbol, 16'd0, 4'd0};
                end
                else
                begin
                    bumped = list_count[hit];
                    if (bumped != COUNT_MAX)
                    begin
                        bumped++;
                    end
                    // slide past every directly preceding smaller count
                    slot = hit;
                    while (slot > 0 && list_count[slot - 1] < bumped)
                    begin
                        list_symbol[slot] = list_symbol[slot - 1];
                        list_count[slot]  = list_count[slot - 1];
                        slot--;
                    end
                    list_symbol[slot] = r.symbol;
                    list_count[slot]  = bumped;
                    res = '{ST_OK, r.symbol, bumped, 4'(slot)};
                end
            end
            REQ_READ:
            begin
                if (int'(r.index) < list_fill)
                begin
                    res = '{ST_OK, list_symbol[r.index], list_count[r.index], r.index};
                end
            end
            default:
            begin
                res = '{ST_BAD_INDEX, 8'h00, 16'd0, 4'd0};
            end
        endcase
        return res;
    endfunction

    function automatic int pick_wait();
        if (no_idle)
        begin
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Random mix. Most locates hit a symbol that is in the list, so entries
    // keep climbing past each other. The rest are misses, reads, refused
    // appends and the unused code. Unused fields still carry random bits.
    function automatic request_t random_request();
        request_t r;
        int       roll;

        r.symbol = 8'($urandom);
        r.index  = 4'($urandom);
        roll     = $urandom_range(0, 99);
        if (roll < 55 && list_fill > 0)
        begin
            r.kind   = REQ_LOCATE;
            r.symbol = list_symbol[$urandom_range(0, list_fill - 1)];
        end
        else if (roll < 65)
        begin
            r.kind = REQ_LOCATE;
        end
        else if (roll < 85)
        begin
            r.kind = REQ_READ;
        end
        else if (roll < 93)
        begin
            r.kind = REQ_APPEND;
        end
        else
        begin
            r.kind = REQ_RESERVED;
        end
        return r;
    endfunction

    // Offer one request and hold it until the block takes it. valid stays
    // high into the next request when no gap is drawn. The model runs in
    // this process right at the accepting edge. The result cannot come
    // back before the next edge.
    task automatic issue_request(input request_t r, input logic typed,
                                 input result_t want);
        int      gap;
        result_t modeled;

        gap = pick_wait();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= r.kind;
        req_ch.symbol   <= r.symbol;
        req_ch.index    <= r.index;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        modeled = apply_request(r);
        expected_q.push_back(typed ? want : modeled);
    endtask

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
        end
    endtask

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        result_t want;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                error_count++;
                $display("%0t: result with none expected, expected nothing, actual %0h/%0h/%0h/%0h",
                         $time, rsp_ch.status, rsp_ch.symbol_out, rsp_ch.count_out,
                         rsp_ch.position);
            end
            else
            begin
                want = expected_q.pop_front();
                compare_field("status",     16'(want.status),     16'(rsp_ch.status));
                compare_field("symbol_out", 16'(want.symbol_out), 16'(rsp_ch.symbol_out));
                compare_field("count_out",  want.count_out,       rsp_ch.count_out);
                compare_field("position",   16'(want.position),   16'(rsp_ch.position));
            end
        end
    end

    // Receiver: a random stall before each result. A single long hold
    // partway through lets requests pile up until the block stops taking
    // them.
    initial
    begin : result_sink
        int stall;

        rsp_ch.ready <= 1'b0;
        results_taken = 0;
        do
        begin
            @(posedge clk);
        end
        while (!rst_n);
        forever
        begin
            stall = pick_wait();
            if (results_taken == HOLD_AT)
            begin
                stall = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!rsp_ch.valid);
            results_taken++;
        end
    end

    // Run limit.
    initial
    begin
        #(RUN_LIMIT);
        $display("frequency_ordered_list_locate_test failed");
        $finish;
    end

    // Reset, stimulus and the final verdict.
    initial
    begin : request_source
        clk             = 1'b0;
        rst_n          <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_APPEND;
        req_ch.symbol   <= 8'h00;
        req_ch.index    <= 4'd0;
        list_fill       = 0;
        error_count     = 0;
        no_idle         = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < DIRECTED_ROWS; row++)
        begin
            issue_request(DIRECTED[row].req, DIRECTED[row].typed, DIRECTED[row].want);
        end

        // Random part. Now and then both sides switch to a run with no gaps.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 99) == 0)
            begin
                no_idle = !no_idle;
            end
            issue_request(random_request(), 1'b0, BY_MODEL);
        end
        no_idle = 1'b0;
        req_ch.valid <= 1'b0;

        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_q.size() == 0)
        begin
            $display("frequency_ordered_list_locate_test passed");
        end
        else
        begin
            $display("frequency_ordered_list_locate_test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/fol_pkg.sv
sv/fol_req_if.sv
sv/fol_rsp_if.sv
sv/fol_cell.sv
sv/frequency_ordered_list_locate.sv
sim/frequency_ordered_list_locate_test.sv
